// ===== src/lol_pkg.sv =====
// ============================================================================
// lol_pkg: shared types and constants of the LRU order list
// Command and status codes, controller states and the control word that the
// controller hands to the datapath.
// ============================================================================
package lol_pkg;

	localparam int FRAMES_DEF = 64;
	localparam int PAGE_W     = 16;
	localparam int FRAME_W    = 6;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_TOUCH  = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_EVICT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CTL_IDLE   = 1'b0,
		CTL_UPDATE = 1'b1
	} ctl_state_t;

	// capture: latch the item and the match vector of the cell row.
	// commit: apply the update to the cells and load the result register.
	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_cmd_t;

endpackage

// ===== src/lol_req_if.sv =====
// ============================================================================
// lol_req_if: command channel of the LRU order list
// Carries one command item with valid/ready flow control.
// ============================================================================
interface lol_req_if;
	logic                         valid;
	logic                         ready;
	lol_pkg::cmd_t                cmd;
	logic [lol_pkg::PAGE_W-1:0]  page_id;
	logic [lol_pkg::FRAME_W-1:0] frame_num;

	modport source (output valid, output cmd, output page_id, output frame_num, input ready);
	modport sink   (input valid, input cmd, input page_id, input frame_num, output ready);
endinterface

// ===== src/lol_rsp_if.sv =====
// ============================================================================
// lol_rsp_if: result channel of the LRU order list
// Carries one result item with valid/ready flow control.
// ============================================================================
interface lol_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [lol_pkg::PAGE_W-1:0] page_out;
	lol_pkg::status_t            status;

	modport source (output valid, output page_out, output status, input ready);
	modport sink   (input valid, input page_out, input status, output ready);
endinterface

// ===== src/lru_order_list.sv =====
// ============================================================================
// lru_order_list: recency order of a buffer pool's (page, frame) pairs
// Top level joining the controller and the cell-row datapath.
// ============================================================================
// Usage:
// Commands arrive on the req channel (cmd, page_id, frame_num) and every
// command produces exactly one item on the rsp channel (page_out, status).
// The list keeps up to FRAMES entries, the least recent at the head.
// Append adds a pair at the rear, touch moves a page's entry to the rear,
// remove drops the entry holding a frame and evict drops the head; the last
// two return the dropped page in page_out, which is zero otherwise.
// Each item passes an accept step and an update step: in the accept cycle
// every cell compares against the key in parallel and the match vector is
// registered; in the update step, once the result register is free, the
// cell row shifts and the result register is loaded. The block takes one
// item at a time, and the two-state controller sequences these steps.
// The result register parts the two sides: a new item is accepted while an
// earlier result still waits. If the receiver stalls, the block holds the
// next item in its update step until the result register frees up.
// Reset empties the list and drops any pending result; the cell contents
// need no clearing, since only cells below the entry count are ever read.
module lru_order_list #(
	parameter int FRAMES = lol_pkg::FRAMES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lol_req_if.sink    req,
	lol_rsp_if.source  rsp
);

	lol_pkg::ctl_cmd_t ctl;

	// Sequencer: accept, then commit when the result register is free.
	lol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	// Cell row with parallel compare and shift-down compaction.
	lol_datapath #(
		.FRAMES (FRAMES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd       (req.cmd),
		.page_id   (req.page_id),
		.frame_num (req.frame_num),
		.page_out  (rsp.page_out),
		.status    (rsp.status)
	);

endmodule

// ===== src/lol_ctrl.sv =====
// ============================================================================
// lol_ctrl: controller of the LRU order list
// Two-state sequencer that accepts an item, commits it once the result
// register is free, and tracks the result valid flag.
// ============================================================================
module lol_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lol_pkg::ctl_cmd_t ctl
);

	lol_pkg::ctl_state_t state_q;
	lol_pkg::ctl_state_t state_d;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lol_pkg::CTL_IDLE: begin
				if (in_valid) begin
					state_d = lol_pkg::CTL_UPDATE;
				end
			end
			lol_pkg::CTL_UPDATE: begin
				if (out_free) begin
					state_d = lol_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_d = lol_pkg::CTL_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = (state_q == lol_pkg::CTL_IDLE);
		ctl.capture = (state_q == lol_pkg::CTL_IDLE) && in_valid;
		ctl.commit  = (state_q == lol_pkg::CTL_UPDATE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lol_pkg::CTL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/lol_datapath.sv =====
// ============================================================================
// lol_datapath: cell row and result register of the LRU order list
// Each cell holds one (page, frame) pair; all cells compare in parallel and
// shift toward the head to close a gap.
// ============================================================================
module lol_datapath #(
	parameter int FRAMES = lol_pkg::FRAMES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lol_pkg::ctl_cmd_t            ctl,
	input  lol_pkg::cmd_t                cmd,
	input  logic [lol_pkg::PAGE_W-1:0]  page_id,
	input  logic [lol_pkg::FRAME_W-1:0] frame_num,
	output logic [lol_pkg::PAGE_W-1:0]  page_out,
	output lol_pkg::status_t             status
);

	localparam int CW = $clog2(FRAMES + 1);
	localparam int LW = $clog2(FRAMES);

	logic [lol_pkg::PAGE_W-1:0]  cell_page_q  [FRAMES];
	logic [lol_pkg::FRAME_W-1:0] cell_frame_q [FRAMES];
	logic [CW-1:0]               count_q;

	lol_pkg::cmd_t                cmd_s1;
	logic [lol_pkg::PAGE_W-1:0]  page_s1;
	logic [lol_pkg::FRAME_W-1:0] frame_s1;
	logic [FRAMES-1:0]           match_s1;
	logic [FRAMES-1:0]           match_d;

	logic [FRAMES-1:0]           pfx;
	logic [FRAMES-1:0]           first;
	logic                        found;
	logic [lol_pkg::PAGE_W-1:0]  hit_page;
	logic [lol_pkg::FRAME_W-1:0] hit_frame;
	logic [CW-1:0]               last;
	lol_pkg::status_t            status_d;
	logic                        do_op;

	logic [lol_pkg::PAGE_W-1:0]  page_out_q;
	lol_pkg::status_t            status_q;

	// Parallel compare of every live cell against the incoming key.
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			unique case (cmd)
				lol_pkg::CMD_TOUCH:  match_d[i] = (cell_page_q[i] == page_id);
				lol_pkg::CMD_REMOVE: match_d[i] = (cell_frame_q[i] == frame_num);
				lol_pkg::CMD_EVICT:  match_d[i] = (i == 0);
				default:             match_d[i] = 1'b0;
			endcase
			match_d[i] = match_d[i] && (CW'(i) < count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_s1   <= cmd;
			page_s1  <= page_id;
			frame_s1 <= frame_num;
			match_s1 <= match_d;
		end
	end

	// Inclusive prefix OR: set from the first match up to the top cell.
	always_comb begin
		pfx = match_s1;
		for (int s = 0; s < LW; s++) begin
			pfx = pfx | (pfx << (1 << s));
		end
	end

	assign first = match_s1 & ~(pfx << 1);
	assign found = |match_s1;
	assign last  = count_q - CW'(1);

	always_comb begin
		hit_page  = '0;
		hit_frame = '0;
		for (int i = 0; i < FRAMES; i++) begin
			hit_page  = hit_page | ({lol_pkg::PAGE_W{first[i]}} & cell_page_q[i]);
			hit_frame = hit_frame | ({lol_pkg::FRAME_W{first[i]}} & cell_frame_q[i]);
		end
	end

	always_comb begin
		priority if (cmd_s1 == lol_pkg::CMD_APPEND) begin
			status_d = (count_q == CW'(FRAMES)) ? lol_pkg::ST_FULL : lol_pkg::ST_OK;
		end else if (count_q == '0) begin
			status_d = lol_pkg::ST_EMPTY;
		end else if (!found) begin
			status_d = lol_pkg::ST_NOTFOUND;
		end else begin
			status_d = lol_pkg::ST_OK;
		end
	end

	assign do_op = ctl.commit && (status_d == lol_pkg::ST_OK);

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		logic [lol_pkg::PAGE_W-1:0]  nb_page;
		logic [lol_pkg::FRAME_W-1:0] nb_frame;

		if (g < FRAMES - 1) begin : g_nb
			assign nb_page  = cell_page_q[g + 1];
			assign nb_frame = cell_frame_q[g + 1];
		end else begin : g_top
			assign nb_page  = cell_page_q[g];
			assign nb_frame = cell_frame_q[g];
		end

		// Append writes the first free cell; touch moves the hit to the rear;
		// touch, remove and evict shift the cells above the hit one step down.
		always_ff @(posedge clk) begin
			if (do_op) begin
				priority if (cmd_s1 == lol_pkg::CMD_APPEND) begin
					if (count_q == CW'(g)) begin
						cell_page_q[g]  <= page_s1;
						cell_frame_q[g] <= frame_s1;
					end
				end else if (cmd_s1 == lol_pkg::CMD_TOUCH && last == CW'(g)) begin
					cell_page_q[g]  <= page_s1;
					cell_frame_q[g] <= hit_frame;
				end else if (pfx[g]) begin
					cell_page_q[g]  <= nb_page;
					cell_frame_q[g] <= nb_frame;
				end else begin
					cell_page_q[g]  <= cell_page_q[g];
					cell_frame_q[g] <= cell_frame_q[g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_op) begin
			unique case (cmd_s1)
				lol_pkg::CMD_APPEND: count_q <= count_q + CW'(1);
				lol_pkg::CMD_TOUCH:  count_q <= count_q;
				default:             count_q <= last;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status_q <= status_d;
			if (do_op && (cmd_s1 == lol_pkg::CMD_REMOVE || cmd_s1 == lol_pkg::CMD_EVICT)) begin
				page_out_q <= hit_page;
			end else begin
				page_out_q <= '0;
			end
		end
	end

	assign page_out = page_out_q;
	assign status   = status_q;

endmodule

// ===== src/lol_checker.sv =====
// ============================================================================
// lol_checker: port-level checks of the LRU order list
// Watches the req and rsp channels over time; bound to the top level.
// ============================================================================
module lol_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [lol_pkg::PAGE_W-1:0] rsp_page_out,
	input lol_pkg::status_t            rsp_status
);

	// A stalled result holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_page_out) && $stable(rsp_status))
		else $error("stalled result changed");

	// A failed command never reports a page.
	a_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != lol_pkg::ST_OK |-> rsp_page_out == '0)
		else $error("page reported with failing status");

	// One item at a time: no accept in the cycle after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while another is in work");

	// With a free result register the update step does not stall, so the result shows.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (!rsp_valid || rsp_ready) |-> ##2 rsp_valid)
		else $error("result missing two cycles after accept");

endmodule

bind lru_order_list lol_checker u_lol_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_page_out (rsp.page_out),
	.rsp_status   (rsp.status)
);

// ===== tb/tb_lru_order_list.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_lru_order_list: self-checking testbench of the LRU order list
// Drives command items with random gaps, holds its own copy of the recency
// order to predict every result, and compares each result item field by field
// against the oldest prediction. The result side stalls at random and once
// for a long stretch, so the block fills up and holds off new commands.
// ============================================================================
module tb_lru_order_list;

	import lol_pkg::*;

	localparam int LIST_DEPTH = FRAMES_DEF;
	localparam int CLK_HALF   = 2;
	localparam int RAND_ITEMS = 750;

	// Expected content of one result item.
	typedef struct {
		logic [PAGE_W-1:0] page;
		status_t           status;
	} lru_result_t;

	// Recency predictor and the store of results still owed by the block.
	// The head of the list is the least recent entry, as in the hardware.
	class recency_board;
		logic [PAGE_W-1:0]  pages[$];
		logic [FRAME_W-1:0] frames[$];
		lru_result_t        owed[$];
		int                 errors;
		int                 done_count;

		function void note_item(cmd_t cmd, logic [PAGE_W-1:0] page,
				logic [FRAME_W-1:0] frame);
			lru_result_t res;
			int          pos;
			res.page   = '0;
			res.status = ST_OK;
			pos        = -1;
			if (cmd == CMD_APPEND) begin
				if (pages.size() >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					pages.push_back(page);
					frames.push_back(frame);
				end
			end else if (pages.size() == 0) begin
				res.status = ST_EMPTY;
			end else if (cmd == CMD_TOUCH) begin
				// The match nearest the head wins when a page is listed twice.
				for (int i = 0; i < pages.size(); i++) begin
					if (pos < 0 && pages[i] == page) begin
						pos = i;
					end
				end
				if (pos < 0) begin
					res.status = ST_NOTFOUND;
				end else if (pos != pages.size() - 1) begin
					// The entry moves to the rear with its own frame.
					pages.push_back(pages[pos]);
					frames.push_back(frames[pos]);
					pages.delete(pos);
					frames.delete(pos);
				end
			end else if (cmd == CMD_REMOVE) begin
				for (int i = 0; i < frames.size(); i++) begin
					if (pos < 0 && frames[i] == frame) begin
						pos = i;
					end
				end
				if (pos < 0) begin
					res.status = ST_NOTFOUND;
				end else begin
					res.page = pages[pos];
					pages.delete(pos);
					frames.delete(pos);
				end
			end else begin
				res.page = pages.pop_front();
				void'(frames.pop_front());
			end
			owed.push_back(res);
		endfunction

		function void check_result(logic [PAGE_W-1:0] page, status_t status);
			lru_result_t exp_res;
			done_count++;
			if (owed.size() == 0) begin
				report_error($sformatf("result page=%h status=%s with nothing owed",
					page, status.name()));
			end else begin
				exp_res = owed.pop_front();
				if (page !== exp_res.page) begin
					report_error($sformatf("result %0d page_out: expected %h, got %h",
						done_count, exp_res.page, page));
				end
				if (status !== exp_res.status) begin
					report_error($sformatf("result %0d status: expected %s, got %s",
						done_count, exp_res.status.name(), status.name()));
				end
			end
		endfunction

		function void report_error(string msg);
			if (errors < 10) begin
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
			errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lol_req_if req_ch ();
	lol_rsp_if rsp_ch ();

	lru_order_list #(
		.FRAMES(LIST_DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	recency_board board = new();

	// Sender idling is switched off for a window of the random part.
	bit sender_quiet;

	initial begin
		clk = 1'b0;
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	// Every input of the block has a known value from time zero on.
	initial begin
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.cmd       <= CMD_APPEND;
		req_ch.page_id   <= '0;
		req_ch.frame_num <= '0;
		rsp_ch.ready     <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Both handshakes are sampled at the same edge at which the block sees
	// them. A result always belongs to an item accepted at an earlier edge, so
	// the check runs before the new item is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				board.check_result(rsp_ch.page_out, rsp_ch.status);
			end
			if (req_ch.valid && req_ch.ready) begin
				board.note_item(req_ch.cmd, req_ch.page_id, req_ch.frame_num);
			end
		end
	end

	// Result side. It stalls at random with an 11 percent chance, runs a stretch
	// without stalls, and once holds off long enough for the block to fill up
	// and refuse new commands while the sender keeps offering them.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && board.done_count >= 600) begin
				hold_done = 1;
				hold_left = 120;
				rsp_ch.ready <= 1'b0;
			end else if (board.done_count >= 300 && board.done_count < 450) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 11);
			end
			@(posedge clk);
		end
	end

	// Picks a page that is listed most of the time, so that touches hit;
	// otherwise a small pool for duplicates or any 16-bit value.
	function automatic logic [PAGE_W-1:0] pick_page();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60 && board.pages.size() > 0) begin
			return board.pages[$urandom_range(board.pages.size() - 1)];
		end else if (roll < 75) begin
			return PAGE_W'($urandom_range(15));
		end
		return PAGE_W'($urandom);
	endfunction

	function automatic logic [FRAME_W-1:0] pick_frame();
		if ($urandom_range(99) < 60 && board.frames.size() > 0) begin
			return board.frames[$urandom_range(board.frames.size() - 1)];
		end
		return FRAME_W'($urandom);
	endfunction

	// Offers one command item and returns at the edge that accepts it. A gap
	// before the item lowers valid ahead of its wait, so valid never gets two
	// assignments in one step.
	task automatic issue_cmd(cmd_t cmd, logic [PAGE_W-1:0] page,
			logic [FRAME_W-1:0] frame);
		if (!sender_quiet && $urandom_range(99) < 11) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= cmd;
		req_ch.page_id   <= page;
		req_ch.frame_num <= frame;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
	endtask

	// Stimulus. The directed part walks the empty list, a single entry, a
	// duplicated page and removal by frame. The random part then cycles
	// through fill, mixed and drain phases, so the list runs full and empty
	// several times.
	initial begin
		int   phase;
		int   roll;
		cmd_t cmd;
		sender_quiet = 0;
		@(posedge clk iff arst_n);

		// Touch, remove and evict on an empty list.
		issue_cmd(CMD_EVICT,  16'h0000, 6'd0);
		issue_cmd(CMD_TOUCH,  16'hFFFF, 6'd63);
		issue_cmd(CMD_REMOVE, 16'h0000, 6'd0);
		// A single entry: touching the rear changes nothing.
		issue_cmd(CMD_APPEND, 16'hFFFF, 6'd63);
		issue_cmd(CMD_TOUCH,  16'hFFFF, 6'd0);
		issue_cmd(CMD_TOUCH,  16'h0000, 6'd63);
		issue_cmd(CMD_REMOVE, 16'hFFFF, 6'd0);
		// Duplicate page and frame; touch and remove hit the one nearest the head.
		issue_cmd(CMD_APPEND, 16'h0000, 6'd0);
		issue_cmd(CMD_APPEND, 16'hAAAA, 6'd21);
		issue_cmd(CMD_APPEND, 16'hFFFF, 6'd42);
		issue_cmd(CMD_APPEND, 16'h5555, 6'd63);
		issue_cmd(CMD_TOUCH,  16'hFFFF, 6'd0);
		issue_cmd(CMD_TOUCH,  16'hAAAA, 6'd63);
		issue_cmd(CMD_REMOVE, 16'h1234, 6'd63);
		issue_cmd(CMD_REMOVE, 16'h0000, 6'd42);
		issue_cmd(CMD_EVICT,  16'hFFFF, 6'd63);
		issue_cmd(CMD_REMOVE, 16'h0000, 6'd21);
		issue_cmd(CMD_TOUCH,  16'hFFFF, 6'd0);
		issue_cmd(CMD_EVICT,  16'h0000, 6'd0);
		issue_cmd(CMD_EVICT,  16'h0000, 6'd0);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			sender_quiet = (n >= 300 && n < 450);
			phase = (n / 125) % 3;
			roll  = $urandom_range(99);
			if (phase == 0) begin
				if (roll < 85) cmd = CMD_APPEND;
				else if (roll < 90) cmd = CMD_TOUCH;
				else if (roll < 95) cmd = CMD_REMOVE;
				else cmd = CMD_EVICT;
			end else if (phase == 1) begin
				if (roll < 25) cmd = CMD_APPEND;
				else if (roll < 50) cmd = CMD_TOUCH;
				else if (roll < 75) cmd = CMD_REMOVE;
				else cmd = CMD_EVICT;
			end else begin
				if (roll < 10) cmd = CMD_APPEND;
				else if (roll < 20) cmd = CMD_TOUCH;
				else if (roll < 55) cmd = CMD_REMOVE;
				else cmd = CMD_EVICT;
			end
			issue_cmd(cmd, pick_page(), pick_frame());
		end
		req_ch.valid <= 1'b0;

		// Drain the owed results, then keep watching the result channel for any
		// stray result item.
		while (board.owed.size() > 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.owed.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
